>>> rtl/core/tcsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text stream filter package
// Shared constants, payload types and the work descriptor passed from the
// classifying front end to the output sequencer.
// ----------------------------------------------------------------------------
package tcsf_pkg;

	localparam int COUNT_DIGITS = 9;
	localparam int MAX_OUT      = 14;
	localparam int MIN_WIDTH    = 6;
	localparam int Q_DEPTH      = 4;

	localparam int SIG_W   = $clog2(COUNT_DIGITS + 1);
	localparam int DIG_W   = $clog2(COUNT_DIGITS);
	localparam int LEN_W   = $clog2(MAX_OUT + 1);
	localparam int SUM_W   = LEN_W + 1;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_I      = 8'h49;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_DEL    = 8'h7F;
	localparam logic [7:0] CTRL_TOP  = 8'h20;
	localparam logic [7:0] CTRL_OFS  = 8'h40;

	typedef enum logic [2:0] {
		CFG_NUMBER_LINES         = 3'd0,
		CFG_NUMBER_NONBLANK_ONLY = 3'd1,
		CFG_SQUEEZE_BLANK        = 3'd2,
		CFG_SHOW_ENDS            = 3'd3,
		CFG_SHOW_TABS            = 3'd4,
		CFG_SHOW_NONPRINTING     = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic number_lines;
		logic number_nonblank_only;
		logic squeeze_blank;
		logic show_ends;
		logic show_tabs;
		logic show_nonprinting;
	} cfg_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       file_start;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} out_item_t;

	typedef logic [COUNT_DIGITS-1:0][3:0] bcd_t;

	typedef struct packed {
		logic                 has_num;
		bcd_t                 digits;
		logic [SIG_W-1:0]     sig;
		logic [SIG_W-1:0]     width;
		logic [3:0][7:0]      body;
		logic [LEN_W-1:0]     len;
	} desc_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

>>> rtl/core/text_cat_stream_filter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text stream filter
// Line numbering, blank-line squeezing and visible control characters for a
// byte-wide text stream.
// ----------------------------------------------------------------------------
// One text byte is taken per request and expands into zero to fourteen output
// bytes, the last one flagged. The output sequencer sends one byte per clock
// while out_stall is low, and an item yields one byte for plain text and up to
// fourteen for a numbered line start with an escape; a squeezed blank line
// yields no output byte. Input requests are taken every cycle while the
// four-entry descriptor queue between the front end and the sequencer has
// room. Configuration writes are always ready.
module text_cat_stream_filter_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  tcsf_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output tcsf_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  tcsf_pkg::cfg_idx_t  cfg_index,
	input  logic                cfg_data
);
	import tcsf_pkg::*;

	cfg_t    cfg_q;
	q_stat_t q_stat;
	logic    push;
	desc_t   push_desc;
	logic    pop;
	desc_t   head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_NUMBER_LINES:         cfg_q.number_lines         <= cfg_data;
				CFG_NUMBER_NONBLANK_ONLY: cfg_q.number_nonblank_only <= cfg_data;
				CFG_SQUEEZE_BLANK:        cfg_q.squeeze_blank        <= cfg_data;
				CFG_SHOW_ENDS:            cfg_q.show_ends            <= cfg_data;
				CFG_SHOW_TABS:            cfg_q.show_tabs            <= cfg_data;
				CFG_SHOW_NONPRINTING:     cfg_q.show_nonprinting     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	tcsf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.q_stat    (q_stat),
		.push      (push),
		.push_desc (push_desc)
	);

	tcsf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	tcsf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> !q_stat.empty)
		else $error("Queue is empty after a descriptor was written.");

	a_item_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_data.last |=> out_valid)
		else $error("Output stopped in the middle of an item.");

	a_sig_range: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> push_desc.sig >= SIG_W'(1) && push_desc.sig <= SIG_W'(COUNT_DIGITS)
			&& push_desc.len != '0)
		else $error("Descriptor has a bad digit count or length.");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("Descriptor removed from an empty queue.");

endmodule

>>> rtl/core/tcsf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text stream filter front end
// Accepts input bytes, tracks line state and the line counter, and turns each
// byte that is not squeezed out into a descriptor of the output it produces.
// ----------------------------------------------------------------------------
module tcsf_front (
	input  logic              clk,
	input  logic              arst_n,
	input  tcsf_pkg::cfg_t    cfg,
	input  logic              in_valid,
	output logic              in_stall,
	input  tcsf_pkg::in_item_t in_data,
	input  tcsf_pkg::q_stat_t q_stat,
	output logic              push,
	output tcsf_pkg::desc_t   push_desc
);
	import tcsf_pkg::*;

	bcd_t             count_q;
	bcd_t             count_nxt;
	logic             at_line_start_q;
	logic [1:0]       newline_run_q;

	logic             accept;
	logic [7:0]       c;
	logic             is_nl;
	logic             ls;
	logic [1:0]       run;
	logic [1:0]       run_nxt;
	logic             drop;
	logic             num;
	logic             carry;
	logic [SIG_W-1:0] sig;
	logic [SIG_W-1:0] width;
	logic [7:0]       low;
	logic [7:0]       t0;
	logic [7:0]       t1;
	logic [2:0]       tlen;
	logic [3:0][7:0]  body;
	logic [2:0]       blen;
	logic [SUM_W-1:0] sum;
	logic [LEN_W-1:0] len;

	assign in_stall = q_stat.full;
	assign accept   = in_valid && !in_stall;
	assign c        = in_data.in_byte;
	assign is_nl    = (c == CH_NL);
	assign ls       = in_data.file_start ? 1'b1 : at_line_start_q;
	assign run      = in_data.file_start ? 2'd1 : newline_run_q;
	assign drop     = is_nl && cfg.squeeze_blank && (run >= 2'd2);
	assign run_nxt  = is_nl ? ((run < 2'd2) ? run + 2'd1 : run) : 2'd0;
	assign num      = ls && cfg.number_lines && !(cfg.number_nonblank_only && is_nl);

	always_comb begin
		sig = SIG_W'(1);
		for (int i = 1; i < COUNT_DIGITS; i++) begin
			if (count_q[i] != 4'd0) begin
				sig = SIG_W'(i + 1);
			end
		end
		width = (sig > SIG_W'(MIN_WIDTH)) ? sig : SIG_W'(MIN_WIDTH);
	end

	always_comb begin
		count_nxt = count_q;
		carry     = 1'b1;
		for (int i = 0; i < COUNT_DIGITS; i++) begin
			if (carry) begin
				if (count_q[i] == 4'd9) begin
					count_nxt[i] = 4'd0;
				end else begin
					count_nxt[i] = count_q[i] + 4'd1;
					carry        = 1'b0;
				end
			end
		end
		if (carry) begin
			count_nxt = count_q;
		end
	end

	always_comb begin
		low  = c[7] ? {1'b0, c[6:0]} : c;
		t0   = low;
		t1   = CH_QMARK;
		tlen = 3'd1;
		if (low < CTRL_TOP) begin
			t0   = CH_CARET;
			t1   = low + CTRL_OFS;
			tlen = 3'd2;
		end else if (low == CH_DEL) begin
			t0   = CH_CARET;
			t1   = CH_QMARK;
			tlen = 3'd2;
		end
		body = '0;
		blen = 3'd1;
		if (is_nl) begin
			if (cfg.show_ends) begin
				body[0] = CH_DOLLAR;
				body[1] = CH_NL;
				blen    = 3'd2;
			end else begin
				body[0] = CH_NL;
			end
		end else if (c == CH_TAB) begin
			if (cfg.show_tabs) begin
				body[0] = CH_CARET;
				body[1] = CH_I;
				blen    = 3'd2;
			end else begin
				body[0] = CH_TAB;
			end
		end else if (cfg.show_nonprinting) begin
			if (c[7]) begin
				body[0] = CH_M;
				body[1] = CH_DASH;
				body[2] = t0;
				body[3] = t1;
				blen    = tlen + 3'd2;
			end else begin
				body[0] = t0;
				body[1] = t1;
				blen    = tlen;
			end
		end else begin
			body[0] = c;
		end
		sum = (num ? SUM_W'(width) + SUM_W'(1) : SUM_W'(0)) + SUM_W'(blen);
		len = (sum > SUM_W'(MAX_OUT)) ? LEN_W'(MAX_OUT) : sum[LEN_W-1:0];
	end

	assign push              = accept && !drop;
	assign push_desc.has_num = num;
	assign push_desc.digits  = count_q;
	assign push_desc.sig     = sig;
	assign push_desc.width   = width;
	assign push_desc.body    = body;
	assign push_desc.len     = len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q         <= bcd_t'(1);
			at_line_start_q <= 1'b1;
			newline_run_q   <= 2'd1;
		end else if (accept) begin
			newline_run_q   <= run_nxt;
			at_line_start_q <= drop ? ls : is_nl;
			if (push && num) begin
				count_q <= count_nxt;
			end
		end
	end

endmodule

>>> rtl/core/tcsf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text stream filter descriptor queue
// Small first-in first-out buffer that decouples the front end from the
// output sequencer.
// ----------------------------------------------------------------------------
module tcsf_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tcsf_pkg::desc_t   push_desc,
	input  logic              pop,
	output tcsf_pkg::desc_t   head,
	output tcsf_pkg::q_stat_t q_stat
);
	import tcsf_pkg::*;

	desc_t              mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	assign head         = mem_q[rd_ptr_q];
	assign q_stat.full  = (count_q == Q_CNT_W'(Q_DEPTH));
	assign q_stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + Q_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - Q_CNT_W'(1);
			end
		end
	end

endmodule

>>> rtl/core/tcsf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text stream filter output sequencer
// Walks the descriptor at the head of the queue and sends one output byte per
// cycle, while the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module tcsf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  tcsf_pkg::desc_t     head,
	input  tcsf_pkg::q_stat_t   q_stat,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output tcsf_pkg::out_item_t out_data
);
	import tcsf_pkg::*;

	logic [LEN_W-1:0] pos_q;
	logic             out_valid_q;
	out_item_t        out_q;

	logic             load;
	logic             is_last;
	logic [SUM_W-1:0] p;
	logic [SUM_W-1:0] pad;
	logic [SUM_W-1:0] w;
	logic [SUM_W-1:0] off;
	logic [SUM_W-1:0] dsel;
	logic [7:0]       ch;

	assign load    = !out_valid_q || !out_stall;
	assign is_last = (pos_q == head.len - LEN_W'(1));
	assign pop     = load && !q_stat.empty && is_last;

	always_comb begin
		p    = SUM_W'(pos_q);
		w    = SUM_W'(head.width);
		pad  = w - SUM_W'(head.sig);
		off  = head.has_num ? p - w - SUM_W'(1) : p;
		dsel = w - SUM_W'(1) - p;
		ch   = head.body[off[1:0]];
		if (head.has_num) begin
			if (p < pad) begin
				ch = CH_SPACE;
			end else if (p < w) begin
				ch = CH_ZERO + {4'd0, head.digits[dsel[DIG_W-1:0]]};
			end else if (p == w) begin
				ch = CH_TAB;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pos_q       <= '0;
		end else if (load) begin
			out_valid_q <= !q_stat.empty;
			if (!q_stat.empty) begin
				pos_q <= is_last ? '0 : pos_q + LEN_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_byte <= ch;
			out_q.last     <= is_last;
		end
	end

endmodule
